// ----- rtl/nutt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest unit tracking table package
// Shared widths, command and outcome codes, sequencer states and item types.
// ----------------------------------------------------------------------------
package nutt_pkg;

  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned SLOTS_DEFAULT = 32;
  localparam int unsigned ID_BITS       = 64;
  localparam int unsigned SLOT_BITS     = 5;
  localparam int unsigned SQ_BITS       = 2 * COORD_BITS;
  localparam int unsigned ACC_BITS      = SQ_BITS + 2;
  localparam int unsigned DIST_BITS     = (ACC_BITS > 64) ? 64 : ACC_BITS;

  typedef enum logic [1:0] {
    CMD_BEGIN   = 2'd0,
    CMD_OBSERVE = 2'd1,
    CMD_END     = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_NPC    = 2'd1,
    KIND_PLAYER = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OUT_REFRESHED = 3'd0,
    OUT_INSERTED  = 3'd1,
    OUT_REPLACED  = 3'd2,
    OUT_DROPPED   = 3'd3,
    OUT_IGNORED   = 3'd4,
    OUT_BEGUN     = 3'd5,
    OUT_SWEPT     = 3'd6
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQR,
    ST_ACC,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic [ID_BITS-1:0]           object_id;
    logic [1:0]                   object_kind;
    logic                         is_self;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    outcome_e             outcome;
    logic [SLOT_BITS-1:0] slot;
    logic [SLOT_BITS-1:0] self_slot;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/nearest_unit_tracking_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest unit tracking table
// Keeps the tracked objects nearest to a reference point in a table of slots.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   in_i  (nutt_pkg::in_item_t)
// out       output     out_valid_o / out_ready_i out_o (nutt_pkg::out_item_t)
//
// Begin frame, end frame and ignored items give their result in the cycle
// after they are accepted. An observe item runs the shared subtract,
// multiply and accumulate unit once per axis for the squared distance, then
// one table read per slot, a drain state and a decision once output is free.
// Reset clears the occupancy, seen and self registers at once; no sweep.
// A result left waiting in the output register holds off the next item.
// ----------------------------------------------------------------------------
module nearest_unit_tracking_table #(
  parameter int unsigned SLOTS = nutt_pkg::SLOTS_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire nutt_pkg::in_item_t  in_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output nutt_pkg::out_item_t      out_o
);

  import nutt_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  state_e state_q, state_d;
  in_item_t item_q, item_d;
  logic signed [COORD_BITS-1:0] refpos_q [3];
  logic signed [COORD_BITS-1:0] refpos_d [3];
  logic [1:0] dim_q, dim_d;
  logic [COORD_BITS-1:0] diff_q, diff_d;
  logic [SQ_BITS-1:0] sq_q, sq_d;
  logic [ACC_BITS-1:0] acc_q, acc_d;
  logic [DIST_BITS-1:0] dist_q, dist_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic ev_valid_q;
  logic [IW-1:0] ev_idx_q;
  logic have_match_q, have_match_d;
  logic have_free_q, have_free_d;
  logic have_far_q, have_far_d;
  logic [IW-1:0] match_q, match_d;
  logic [IW-1:0] free_q, free_d;
  logic [IW-1:0] far_q, far_d;
  logic [DIST_BITS-1:0] far_dist_q, far_dist_d;
  logic [SLOTS-1:0] occ_q, occ_d;
  logic [SLOTS-1:0] seen_q, seen_d;
  logic [IW-1:0] self_q, self_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic [ID_BITS-1:0] id_mem [SLOTS];
  logic [DIST_BITS-1:0] dist_mem [SLOTS];
  logic [ID_BITS-1:0] rd_id_q;
  logic [DIST_BITS-1:0] rd_dist_q;
  logic mem_we;
  logic [IW-1:0] wr_idx;

  logic accept;
  logic out_free;
  logic signed [COORD_BITS-1:0] p_sel;
  logic signed [COORD_BITS-1:0] r_sel;
  logic [COORD_BITS:0] diff_s;
  logic [COORD_BITS:0] diff_mag;
  logic [ACC_BITS-1:0] acc_sum;
  logic [65:0] acc_wide;
  logic occ_e;
  logic id_ok;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign id_ok = (in_i.object_id != '0) &&
                 ((in_i.object_kind == KIND_NPC) || (in_i.object_kind == KIND_PLAYER));

  always_comb begin
    case (dim_q)
      2'd0: begin
        p_sel = item_q.pos_x;
        r_sel = refpos_q[0];
      end
      2'd1: begin
        p_sel = item_q.pos_y;
        r_sel = refpos_q[1];
      end
      default: begin
        p_sel = item_q.pos_z;
        r_sel = refpos_q[2];
      end
    endcase
  end

  assign diff_s   = {r_sel[COORD_BITS-1], r_sel} - {p_sel[COORD_BITS-1], p_sel};
  assign diff_mag = diff_s[COORD_BITS] ? (~diff_s + 1'b1) : diff_s;
  assign acc_sum  = acc_q + ACC_BITS'(sq_q);
  assign acc_wide = 66'(acc_q);
  assign occ_e    = occ_q[ev_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      refpos_q     <= '{default: '0};
      occ_q        <= '0;
      seen_q       <= '0;
      self_q       <= '0;
      out_valid_q  <= 1'b0;
      ev_valid_q   <= 1'b0;
      have_match_q <= 1'b0;
      have_free_q  <= 1'b0;
      have_far_q   <= 1'b0;
      dim_q        <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      refpos_q     <= refpos_d;
      occ_q        <= occ_d;
      seen_q       <= seen_d;
      self_q       <= self_d;
      out_valid_q  <= out_valid_d;
      ev_valid_q   <= (state_q == ST_SCAN);
      have_match_q <= have_match_d;
      have_free_q  <= have_free_d;
      have_far_q   <= have_far_d;
      dim_q        <= dim_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    diff_q     <= diff_d;
    sq_q       <= sq_d;
    acc_q      <= acc_d;
    dist_q     <= dist_d;
    ev_idx_q   <= cnt_q;
    match_q    <= match_d;
    free_q     <= free_d;
    far_q      <= far_d;
    far_dist_q <= far_dist_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      id_mem[wr_idx]   <= item_q.object_id;
      dist_mem[wr_idx] <= dist_q;
    end
    rd_id_q   <= id_mem[cnt_q];
    rd_dist_q <= dist_mem[cnt_q];
  end

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    refpos_d     = refpos_q;
    dim_d        = dim_q;
    diff_d       = diff_q;
    sq_d         = sq_q;
    acc_d        = acc_q;
    dist_d       = dist_q;
    cnt_d        = cnt_q;
    have_match_d = have_match_q;
    have_free_d  = have_free_q;
    have_far_d   = have_far_q;
    match_d      = match_q;
    free_d       = free_q;
    far_d        = far_q;
    far_dist_d   = far_dist_q;
    occ_d        = occ_q;
    seen_d       = seen_q;
    self_d       = self_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    mem_we       = 1'b0;
    wr_idx       = '0;

    if (ev_valid_q) begin
      if (!have_match_q && occ_e && (rd_id_q == item_q.object_id)) begin
        have_match_d = 1'b1;
        match_d      = ev_idx_q;
      end
      if (!have_free_q && !occ_e) begin
        have_free_d = 1'b1;
        free_d      = ev_idx_q;
      end
      if (occ_e && (rd_dist_q > far_dist_q)) begin
        have_far_d = 1'b1;
        far_d      = ev_idx_q;
        far_dist_d = rd_dist_q;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_i;
          out_d.slot = '0;
          out_d.self_slot = SLOT_BITS'(self_q);
          case (in_i.command)
            CMD_BEGIN: begin
              refpos_d[0] = in_i.pos_x;
              refpos_d[1] = in_i.pos_y;
              refpos_d[2] = in_i.pos_z;
              seen_d = '0;
              out_d.outcome = OUT_BEGUN;
              out_valid_d = 1'b1;
            end
            CMD_END: begin
              occ_d = occ_q & seen_q;
              out_d.outcome = OUT_SWEPT;
              out_valid_d = 1'b1;
            end
            CMD_OBSERVE: begin
              if (id_ok) begin
                dim_d   = '0;
                acc_d   = '0;
                state_d = ST_DIFF;
              end else begin
                out_d.outcome = OUT_IGNORED;
                out_valid_d = 1'b1;
              end
            end
            default: begin
              out_d.outcome = OUT_IGNORED;
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_DIFF: begin
        diff_d  = diff_mag[COORD_BITS-1:0];
        state_d = ST_SQR;
      end
      ST_SQR: begin
        sq_d    = SQ_BITS'(diff_q) * SQ_BITS'(diff_q);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        acc_d = acc_sum;
        if (dim_q == 2'd2) begin
          cnt_d        = '0;
          have_match_d = 1'b0;
          have_free_d  = 1'b0;
          have_far_d   = 1'b0;
          far_dist_d   = '0;
          state_d      = ST_SCAN;
        end else begin
          dim_d   = dim_q + 2'd1;
          state_d = ST_DIFF;
        end
      end
      ST_SCAN: begin
        dist_d = (acc_wide > 66'(DIST_MAX)) ? DIST_MAX : acc_q[DIST_BITS-1:0];
        if (cnt_q == LAST_SLOT) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d.slot  = '0;
          if (have_match_q) begin
            out_d.outcome = OUT_REFRESHED;
            wr_idx = match_q;
            mem_we = 1'b1;
          end else if (have_free_q) begin
            out_d.outcome = OUT_INSERTED;
            wr_idx = free_q;
            mem_we = 1'b1;
          end else if (have_far_q && (dist_q < far_dist_q)) begin
            out_d.outcome = OUT_REPLACED;
            wr_idx = far_q;
            mem_we = 1'b1;
          end else begin
            out_d.outcome = OUT_DROPPED;
          end
          if (mem_we) begin
            occ_d[wr_idx]  = 1'b1;
            seen_d[wr_idx] = 1'b1;
            out_d.slot     = SLOT_BITS'(wr_idx);
            if (item_q.is_self) begin
              self_d = wr_idx;
            end
          end
          out_d.self_slot = SLOT_BITS'(self_d);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_seen_within_occupied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seen_q & ~occ_q) == '0)
    else $error("A seen slot is not occupied.");

  a_begin_clears_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_i.command == CMD_BEGIN) |=> seen_q == '0)
    else $error("Begin frame left seen marks set.");

  a_only_sweep_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && (in_i.command == CMD_END)) |=> ($past(occ_q) & ~occ_q) == '0)
    else $error("A slot was freed outside an end frame.");

  a_slot_zero_unless_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.outcome != OUT_REFRESHED) && (out_o.outcome != OUT_INSERTED) &&
    (out_o.outcome != OUT_REPLACED) |-> out_o.slot == '0)
    else $error("Slot is nonzero for a result that wrote no slot.");

endmodule
`default_nettype wire

// ----- dv/nearest_unit_tracking_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest unit tracking table testbench
// Drives framed sequences of begin, observe and end items with random ids,
// kinds and positions, plus ignored and malformed items. A model of the slot
// table in the testbench predicts the outcome, slot and self slot of every
// item, and each result from the block is checked against it in order. The
// sender idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module nearest_unit_tracking_table_test;
  import nutt_pkg::*;

  localparam int unsigned TABLE_SLOTS  = SLOTS_DEFAULT;
  localparam int          ITEM_TARGET  = 1050;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          STALL_LIMIT  = 5000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  typedef struct {
    in_item_t item;
    bit       hold_for_drain;
  } pending_item_t;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_e;
  typedef enum {POS_FULL, POS_AT_REF, POS_NEAR} pos_mode_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  pending_item_t pending_items[$];
  out_item_t     predicted_results[$];
  int            mismatches = 0;

  // Predicted table contents.
  logic [ID_BITS-1:0] track_ids [TABLE_SLOTS];
  bit                 track_player [TABLE_SLOTS];
  logic [63:0]        track_dist [TABLE_SLOTS];
  bit                 track_seen [TABLE_SLOTS];
  longint             ref_pos [3];
  logic [SLOT_BITS-1:0] self_idx;

  int          burst_left = 1;
  int          gap_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_phase_left = 0;
  int unsigned ready_tick = 0;
  int          idle_cycles = 0;

  nearest_unit_tracking_table #(
    .SLOTS(TABLE_SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_item_t predict_track_update(in_item_t it);
    out_item_t   res;
    longint      pos [3];
    longint      diff;
    logic [63:0] sq_dist;
    logic [63:0] far_dist;
    bit          found_match, found_free, found_far;
    int          match_idx, free_idx, far_idx, hit;
    res.outcome   = OUT_IGNORED;
    res.slot      = '0;
    pos[0]        = longint'($signed(it.pos_x));
    pos[1]        = longint'($signed(it.pos_y));
    pos[2]        = longint'($signed(it.pos_z));
    found_match   = 1'b0;
    found_free    = 1'b0;
    found_far     = 1'b0;
    match_idx     = 0;
    free_idx      = 0;
    far_idx       = 0;
    hit           = 0;
    far_dist      = '0;
    sq_dist       = '0;
    case (it.command)
      CMD_BEGIN: begin
        ref_pos = pos;
        foreach (track_seen[k]) track_seen[k] = 1'b0;
        res.outcome = OUT_BEGUN;
      end
      CMD_END: begin
        foreach (track_ids[k]) if (!track_seen[k]) track_ids[k] = '0;
        res.outcome = OUT_SWEPT;
      end
      CMD_OBSERVE: begin
        if (it.object_id != '0 && (it.object_kind == KIND_NPC ||
                                   it.object_kind == KIND_PLAYER)) begin
          // The sum stays below 2^50 at 24-bit coordinates, so it never saturates.
          for (int a = 0; a < 3; a++) begin
            diff = ref_pos[a] - pos[a];
            sq_dist = sq_dist + 64'(diff * diff);
          end
          for (int k = 0; k < TABLE_SLOTS; k++) begin
            if (!found_match && track_ids[k] == it.object_id) begin
              found_match = 1'b1;
              match_idx   = k;
            end
            if (!found_free && track_ids[k] == '0) begin
              found_free = 1'b1;
              free_idx   = k;
            end
            if (track_ids[k] != '0 && track_dist[k] > far_dist) begin
              far_dist  = track_dist[k];
              far_idx   = k;
              found_far = 1'b1;
            end
          end
          if (found_match) begin
            track_dist[match_idx] = sq_dist;
            track_seen[match_idx] = 1'b1;
            hit         = match_idx;
            res.outcome = OUT_REFRESHED;
          end else if (found_free || (found_far && sq_dist < far_dist)) begin
            hit = found_free ? free_idx : far_idx;
            track_ids[hit]    = it.object_id;
            track_player[hit] = (it.object_kind == KIND_PLAYER);
            track_dist[hit]   = sq_dist;
            track_seen[hit]   = 1'b1;
            res.outcome = found_free ? OUT_INSERTED : OUT_REPLACED;
          end else begin
            res.outcome = OUT_DROPPED;
          end
          if (res.outcome != OUT_DROPPED) begin
            res.slot = SLOT_BITS'(hit);
            if (it.is_self) self_idx = SLOT_BITS'(hit);
          end
        end
      end
      default: ;
    endcase
    res.self_slot = self_idx;
    return res;
  endfunction

  function automatic in_item_t make_item(logic [1:0] command, logic [ID_BITS-1:0] id,
                                         logic [1:0] kind, logic self_flag,
                                         logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                         logic [COORD_BITS-1:0] z);
    in_item_t it;
    it.command     = command;
    it.object_id   = id;
    it.object_kind = kind;
    it.is_self     = self_flag;
    it.pos_x       = x;
    it.pos_y       = y;
    it.pos_z       = z;
    return it;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b0, {(COORD_BITS-1){1'b1}}};
      1:       return {1'b1, {(COORD_BITS-1){1'b0}}};
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [COORD_BITS-1:0] near_coord(logic signed [COORD_BITS-1:0] c,
                                                       int spread);
    int offset;
    offset = int'($urandom_range(0, 2 * spread)) - spread;
    return COORD_BITS'(int'(c) + offset);
  endfunction

  function automatic logic [ID_BITS-1:0] random_id();
    logic [ID_BITS-1:0] id;
    id = {$urandom(), $urandom()};
    if (id == '0) id = 64'd1;
    return id;
  endfunction

  task automatic push_item(in_item_t it, bit hold_for_drain = 1'b0);
    pending_item_t p;
    p.item           = it;
    p.hold_for_drain = hold_for_drain;
    pending_items.insert(pending_items.size(), p);
  endtask

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predicted_results.insert(predicted_results.size(), predict_track_update(in_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].hold_for_drain && predicted_results.size() > 0)) begin
          in_i       <= pending_items[0].item;
          in_valid_i <= 1'b1;
          pending_items.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: picks a new stall pattern whenever its phase counter runs out.
  always @(posedge clk_i) begin
    if (ready_phase_left == 0) begin
      ready_mode       = ready_mode_e'($urandom_range(0, 3));
      ready_phase_left = $urandom_range(32, 256);
    end else begin
      ready_phase_left--;
    end
    case (ready_mode)
      READY_ALWAYS: out_ready_i <= 1'b1;
      READY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:      out_ready_i <= (ready_tick % 8 != 0);
    endcase
    ready_tick++;
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual outcome %0d slot %0d self %0d",
                 $time, out_o.outcome, out_o.slot, out_o.self_slot);
      end else begin
        want = predicted_results.pop_front();
        if (out_o.outcome !== want.outcome) begin
          mismatches++;
          $display("%0t: outcome mismatch, expected %0d, actual %0d",
                   $time, want.outcome, out_o.outcome);
        end
        if (out_o.slot !== want.slot) begin
          mismatches++;
          $display("%0t: slot mismatch, expected %0d, actual %0d",
                   $time, want.slot, out_o.slot);
        end
        if (out_o.self_slot !== want.self_slot) begin
          mismatches++;
          $display("%0t: self slot mismatch, expected %0d, actual %0d",
                   $time, want.self_slot, out_o.self_slot);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ID_BITS-1:0]    id_pool [64];
    logic [COORD_BITS-1:0] rx, ry, rz;
    logic [1:0]            kind;
    pos_mode_e             pos_mode;
    int                    item_total, frame_no, count, span, start, spread, pick;

    foreach (track_ids[k]) begin
      track_ids[k]    = '0;
      track_player[k] = 1'b0;
      track_dist[k]   = '0;
      track_seen[k]   = 1'b0;
    end
    ref_pos  = '{0, 0, 0};
    self_idx = '0;

    // Directed part.
    push_item(make_item(CMD_END, '0, KIND_OTHER, 1'b0, '0, '0, '0));
    push_item(make_item(CMD_OBSERVE, '0, KIND_NPC, 1'b0, 24'd5, 24'd5, 24'd5));
    push_item(make_item(CMD_OBSERVE, 64'd1, KIND_OTHER, 1'b1, '0, '0, '0));
    push_item(make_item(CMD_OBSERVE, 64'd1, KIND_UNUSED, 1'b0, '0, '0, '0));
    push_item(make_item(CMD_UNUSED, '1, KIND_PLAYER, 1'b1, '1, '1, '1));
    push_item(make_item(CMD_BEGIN, '0, KIND_OTHER, 1'b0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    push_item(make_item(CMD_OBSERVE, '1, KIND_PLAYER, 1'b1,
                        24'h800000, 24'h800000, 24'h800000));
    push_item(make_item(CMD_OBSERVE, '1, KIND_NPC, 1'b0,
                        24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF));
    push_item(make_item(CMD_OBSERVE, 64'h5555_5555_5555_5555, KIND_NPC, 1'b1,
                        24'h7FFFFE, 24'h7FFFFF, 24'h7FFFFE));
    push_item(make_item(CMD_OBSERVE, 64'hAAAA_AAAA_AAAA_AAAA, KIND_PLAYER, 1'b0,
                        '0, '0, '0));
    push_item(make_item(CMD_END, '0, KIND_OTHER, 1'b0, '0, '0, '0));
    push_item(make_item(CMD_END, '0, KIND_OTHER, 1'b0, '0, '0, '0));
    push_item(make_item(CMD_BEGIN, '0, KIND_OTHER, 1'b0,
                        24'h800000, 24'h800000, 24'h800000), 1'b1);
    push_item(make_item(CMD_OBSERVE, 64'hAAAA_AAAA_AAAA_AAAA, KIND_PLAYER, 1'b0,
                        24'h000010, 24'hFFFFF0, 24'h123456));
    push_item(make_item(CMD_END, '0, KIND_OTHER, 1'b0, '0, '0, '0));
    push_item(make_item(CMD_OBSERVE, 64'd7, KIND_NPC, 1'b1, 24'h7FFFFF, '0, 24'h800000));
    push_item(make_item(CMD_OBSERVE, 64'h5555_5555_5555_5555, KIND_PLAYER, 1'b0,
                        24'h800001, 24'h800001, 24'h800001));
    item_total = 17;

    // Random frames: mostly well-formed, with some noise and missing ends.
    foreach (id_pool[i]) id_pool[i] = random_id();
    frame_no = 0;
    while (item_total < ITEM_TARGET) begin
      repeat ($urandom_range(0, 6)) id_pool[$urandom_range(0, 63)] = random_id();
      pick = $urandom_range(0, 9);
      pos_mode = (pick < 2) ? POS_FULL : (pick < 4) ? POS_AT_REF : POS_NEAR;
      case ($urandom_range(0, 2))
        0:       spread = 3;
        1:       spread = 255;
        default: spread = 65535;
      endcase
      rx = pick_coord();
      ry = pick_coord();
      rz = pick_coord();
      push_item(make_item(CMD_BEGIN, random_id(), kind_e'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)), rx, ry, rz), frame_no % 5 == 0);
      item_total++;
      count = (pos_mode == POS_AT_REF) ? 40 : $urandom_range(8, 48);
      span  = $urandom_range(8, 63);
      start = $urandom_range(0, 63);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          push_item(make_item(2'($urandom_range(0, 3)), random_id(),
                              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              pick_coord(), pick_coord(), pick_coord()));
          item_total++;
        end else if (pick == 1) begin
          kind = ($urandom_range(0, 1) == 0) ? KIND_OTHER : KIND_UNUSED;
          push_item(make_item(CMD_OBSERVE, ($urandom_range(0, 1) == 0) ? '0 : random_id(),
                              ($urandom_range(0, 1) == 0) ? kind : KIND_NPC,
                              1'($urandom_range(0, 1)),
                              pick_coord(), pick_coord(), pick_coord()));
          item_total++;
        end else begin
          kind = ($urandom_range(0, 1) == 0) ? KIND_NPC : KIND_PLAYER;
          case (pos_mode)
            POS_AT_REF: push_item(make_item(CMD_OBSERVE, id_pool[(start + i) % 64], kind,
                                            ($urandom_range(0, 7) == 0), rx, ry, rz));
            POS_FULL:   push_item(make_item(CMD_OBSERVE,
                                            id_pool[$urandom_range(0, span)], kind,
                                            ($urandom_range(0, 7) == 0),
                                            pick_coord(), pick_coord(), pick_coord()));
            default:    push_item(make_item(CMD_OBSERVE,
                                            id_pool[$urandom_range(0, span)], kind,
                                            ($urandom_range(0, 7) == 0),
                                            near_coord(rx, spread), near_coord(ry, spread),
                                            near_coord(rz, spread)));
          endcase
          item_total++;
        end
      end
      if ($urandom_range(0, 9) != 0) begin
        push_item(make_item(CMD_END, random_id(), kind_e'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                            pick_coord()));
        item_total++;
      end
      frame_no++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do begin
      @(posedge clk_i);
    end while (pending_items.size() != 0 || in_valid_i || predicted_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- nearest_unit_tracking_table.f -----
rtl/nutt_pkg.sv
rtl/nearest_unit_tracking_table.sv
dv/nearest_unit_tracking_table_test.sv
